[design/tvdsl_pkg.sv]
// shared constants for the tvd slope limiter
// limiter mode codes, data, fraction and apb widths and register index; no dependencies
package tvdsl_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int MODE_W        = 3;

    localparam logic [MODE_W-1:0] MODE_MINBEE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUPERBEE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALBADA   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LEER     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PASS     = 3'd4;

    localparam logic [0:0] REG_MODE_IDX = 1'b0;

endpackage

[design/tvd_slope_limiter.sv]
// top level of the tvd slope limiter: stream in/out, apb mode register
// depends on tvdsl_pkg and tvdsl_div
//
// One ratio r (signed fixed point, FRAC_BITS fraction bits) in, one limited
// slope out, one item per clock while the output is not stalled. The
// depth is set by the two bit-per-stage dividers (2/(1+r) and the van
// Albada quotient), each FRAC_BITS + 2 quotient stages behind one entry
// register. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stall on the output side
// freezes every stage and nothing is lost or repeated. limiter_mode at
// byte address 0: 0 minbee, 1 superbee, 2 van Albada, 3 van Leer, 4..7
// pass-through. Change it only while no item is in flight.
module tvd_slope_limiter #(
    parameter int FRAC_BITS = tvdsl_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream, tdata: ratio[31:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tvdsl_pkg::DATA_W-1:0]    s_tdata,
    // output stream, tdata: limited_slope[31:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tvdsl_pkg::DATA_W-1:0]    m_tdata,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tvdsl_pkg::APB_AW-1:0]    paddr,
    input  logic [tvdsl_pkg::APB_DW-1:0]    pwdata,
    output logic [tvdsl_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);
    import tvdsl_pkg::*;

    localparam int QW      = FRAC_BITS + 2;          // quotient width, both below 2.0
    localparam int XDEND_W = 2 * FRAC_BITS + 2;      // 2 << 2F
    localparam int XDSOR_W = DATA_W;                 // one + r
    localparam int ADEND_W = 2 * DATA_W - 1;         // r * (one + r)
    localparam int ADSOR_W = 2 * DATA_W - 1 - FRAC_BITS;
    localparam int PIPE    = QW + 5;                 // stage count incl. output
    localparam int LP_W    = QW + DATA_W - 1;        // xi * r
    localparam int RSQ_W   = 2 * DATA_W - 2;         // r * r

    localparam logic [XDEND_W-1:0] XI_DEND = XDEND_W'(2) << (2 * FRAC_BITS);
    localparam logic [DATA_W:0]    ONE     = (DATA_W+1)'(1) << FRAC_BITS;

    // ---------------- configuration ----------------
    logic [MODE_W-1:0] mode_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_MINBEE;
        else if (cfg_wr)
            mode_reg <= pwdata[MODE_W-1:0];
    end

    assign prdata = (paddr[2] == REG_MODE_IDX) ? APB_DW'(mode_reg) : '0;

    // ---------------- pipeline control ----------------
    // single enable: all stages move when the output slot frees up
    logic ce;
    logic v_reg   [0:PIPE-1];
    logic [DATA_W-1:0] raw_reg [0:PIPE-2];

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;
    assign m_tvalid = v_reg[PIPE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE; k++)
                v_reg[k] <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k < PIPE; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // raw ratio rides along for the mode select and pass-through
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            raw_reg[0] <= s_tdata;
            for (int k = 1; k < PIPE - 1; k++)
                raw_reg[k] <= raw_reg[k-1];
        end
    end

    // ---------------- stage 1: products ----------------
    // negative ratios give garbage here; they are masked at the end
    logic [DATA_W-2:0]  rp0;
    logic [DATA_W-1:0]  onep_r0;
    logic [ADEND_W-1:0] num_reg;
    logic [RSQ_W-1:0]   rsq_reg;
    logic [XDSOR_W-1:0] xdsor_reg;

    assign rp0     = raw_reg[0][DATA_W-2:0];
    assign onep_r0 = DATA_W'(ONE) + DATA_W'(rp0);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num_reg   <= ADEND_W'(rp0) * ADEND_W'(onep_r0);
            rsq_reg   <= RSQ_W'(rp0) * RSQ_W'(rp0);
            xdsor_reg <= onep_r0;
        end
    end

    logic [ADSOR_W-1:0] aden;
    assign aden = ADSOR_W'(ONE) + ADSOR_W'(rsq_reg >> FRAC_BITS);

    // ---------------- dividers ----------------
    logic [QW-1:0] xi_q;
    logic [QW-1:0] alb_q;

    tvdsl_div #(
        .DEND_W (XDEND_W),
        .DSOR_W (XDSOR_W),
        .QUO_W  (QW)
    ) u_xi_div (
        .clk      (clk),
        .ce       (ce),
        .dividend (XI_DEND),
        .divisor  (xdsor_reg),
        .quotient (xi_q)
    );

    tvdsl_div #(
        .DEND_W (ADEND_W),
        .DSOR_W (ADSOR_W),
        .QUO_W  (QW)
    ) u_alb_div (
        .clk      (clk),
        .ce       (ce),
        .dividend (num_reg),
        .divisor  (aden),
        .quotient (alb_q)
    );

    // ---------------- van leer product ----------------
    logic [QW-1:0]   xi_reg;
    logic [QW-1:0]   alb_reg;
    logic [LP_W-1:0] lp_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            xi_reg  <= xi_q;
            alb_reg <= alb_q;
            lp_reg  <= LP_W'(xi_q) * LP_W'(raw_reg[PIPE-3][DATA_W-2:0]);
        end
    end

    // ---------------- final select ----------------
    logic [DATA_W-1:0] r_fin;
    logic              positive;
    logic [DATA_W:0]   rp;
    logic [DATA_W:0]   xi_w;
    logic [DATA_W:0]   alb_w;
    logic [DATA_W:0]   lp_w;
    logic [DATA_W:0]   min_rx;
    logic [DATA_W:0]   res;
    logic [DATA_W-1:0] out_next;
    logic [DATA_W-1:0] out_reg;

    assign r_fin    = raw_reg[PIPE-2];
    assign positive = (r_fin != '0) && !r_fin[DATA_W-1];
    assign rp       = (DATA_W+1)'(r_fin[DATA_W-2:0]);
    assign xi_w     = (DATA_W+1)'(xi_reg);
    assign alb_w    = (DATA_W+1)'(alb_reg);
    assign lp_w     = (DATA_W+1)'(lp_reg >> FRAC_BITS);
    assign min_rx   = (rp < xi_w) ? rp : xi_w;

    always_comb
    begin
        res = '0;
        case (mode_reg)
            MODE_MINBEE:
            begin
                if (rp <= ONE)
                    res = rp;
                else
                    res = (xi_w < ONE) ? xi_w : ONE;
            end
            MODE_SUPERBEE:
            begin
                if (rp <= (ONE >> 1))
                    res = rp << 1;
                else if (rp <= ONE)
                    res = ONE;
                else
                    res = (min_rx < (ONE << 1)) ? min_rx : (ONE << 1);
            end
            MODE_ALBADA:
                res = (alb_w < xi_w) ? alb_w : xi_w;
            MODE_LEER:
                res = (lp_w < xi_w) ? lp_w : xi_w;
            default:
                res = '0;
        endcase
    end

    always_comb
    begin
        if (mode_reg >= MODE_PASS)
            out_next = r_fin;
        else if (!positive)
            out_next = '0;
        else
            out_next = res[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_reg <= out_next;
    end

    assign m_tdata = out_reg;

    // ---------------- checks ----------------
    a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (mode_reg < MODE_PASS) |-> !m_tdata[DATA_W-1])
        else $error("limited slope negative in a limiting mode");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (mode_reg < MODE_PASS) |-> ((DATA_W+1)'(m_tdata) <= (ONE << 1)))
        else $error("limited slope above two");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output slot");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(v_reg[PIPE-2]))
        else $error("pipeline moved during output stall");

endmodule

[design/tvdsl_div.sv]
// pipelined restoring divider, one quotient bit per stage
// standalone; quotient must be known to fit in QUO_W bits
module tvdsl_div #(
    parameter int DEND_W = 34,
    parameter int DSOR_W = 32,
    parameter int QUO_W  = 18
) (
    input  logic              clk,
    input  logic              ce,
    input  logic [DEND_W-1:0] dividend,
    input  logic [DSOR_W-1:0] divisor,
    output logic [QUO_W-1:0]  quotient
);

    logic [DSOR_W-1:0] rem_reg  [0:QUO_W];
    logic [QUO_W-1:0]  quo_reg  [0:QUO_W];
    logic [DEND_W-1:0] dend_reg [0:QUO_W-1];
    logic [DSOR_W-1:0] dsor_reg [0:QUO_W-1];

    // entry stage: upper dividend bits are already below the divisor
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0]  <= DSOR_W'(dividend >> QUO_W);
            quo_reg[0]  <= '0;
            dend_reg[0] <= dividend;
            dsor_reg[0] <= divisor;
        end
    end

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        localparam int B = QUO_W - 1 - i;
        logic [DSOR_W:0] shifted;
        logic [DSOR_W:0] diff;
        logic            ge;

        assign shifted = {rem_reg[i], dend_reg[i][B]};
        assign diff    = shifted - {1'b0, dsor_reg[i]};
        assign ge      = shifted >= {1'b0, dsor_reg[i]};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i+1] <= ge ? diff[DSOR_W-1:0] : shifted[DSOR_W-1:0];
                quo_reg[i+1] <= quo_reg[i] | (QUO_W'(ge) << B);
            end
        end

        if (i < QUO_W - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    dend_reg[i+1] <= dend_reg[i];
                    dsor_reg[i+1] <= dsor_reg[i];
                end
            end
        end
    end

    assign quotient = quo_reg[QUO_W];

endmodule
